// File: rtl/bb3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_W_BITS = 11;
    localparam int CFG_H_BITS = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_W_BITS-1:0] FRAME_WIDTH_RST  = CFG_W_BITS'(1024);
    localparam logic [CFG_H_BITS-1:0] FRAME_HEIGHT_RST = CFG_H_BITS'(1024);

    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int TDATA_W = CH_W * NUM_CH;
    localparam int SUM_W   = 12;
    localparam int CNT_W   = 4;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0]  chan_vec_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } edge_t;

    typedef struct packed {
        logic  wr;
        logic  par;
        logic  emit;
        logic  last;
        edge_t edges;
    } scan_t;

endpackage

// File: rtl/bb3_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_scan
// Configuration registers, frame size latch and the input/output raster
// counters; classifies each beat as stored, flushed or ignored.
// ----------------------------------------------------------------------------
module bb3_scan #(
    parameter int  MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W      = $clog2(MAX_WIDTH)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           item_accept,
    input  logic                           drain,
    output logic                           take,
    output bb3_pkg::scan_t                 info,
    output logic [COL_W-1:0]               col
);

    localparam int WD_W  = $clog2(MAX_WIDTH + 2);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int CWW   = (WD_W > bb3_pkg::CFG_W_BITS) ? WD_W : bb3_pkg::CFG_W_BITS;
    localparam int CHW   = (ROW_W > bb3_pkg::CFG_H_BITS) ? ROW_W : bb3_pkg::CFG_H_BITS;

    logic [bb3_pkg::CFG_W_BITS-1:0] width_cfg_reg;
    logic [bb3_pkg::CFG_H_BITS-1:0] height_cfg_reg;

    logic [WD_W-1:0]  act_w_reg, act_w_next;
    logic [ROW_W-1:0] act_h_reg, act_h_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [WD_W-1:0]  lead_cnt_reg, lead_cnt_next;
    logic             lead_done_reg, lead_done_next;
    logic             frame_start_reg, frame_start_next;

    logic [CWW-1:0]   w_ext;
    logic [CHW-1:0]   h_ext;
    logic [WD_W-1:0]  w_clamped;
    logic [ROW_W-1:0] h_clamped;
    logic [WD_W-1:0]  eff_w;
    logic [ROW_W-1:0] eff_h;
    logic             pix_phase;
    logic             col_end;
    logic             out_col_last;
    logic             out_row_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= bb3_pkg::FRAME_WIDTH_RST;
            height_cfg_reg <= bb3_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bb3_pkg::REG_FRAME_WIDTH: begin
                    width_cfg_reg <= cfg_data[bb3_pkg::CFG_W_BITS-1:0];
                end
                bb3_pkg::REG_FRAME_HEIGHT: begin
                    height_cfg_reg <= cfg_data[bb3_pkg::CFG_H_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_ext = CWW'(width_cfg_reg);
    assign h_ext = CHW'(height_cfg_reg);

    always_comb begin
        priority if (w_ext == '0) begin
            w_clamped = WD_W'(1);
        end else if (w_ext > CWW'(MAX_WIDTH)) begin
            w_clamped = WD_W'(MAX_WIDTH);
        end else begin
            w_clamped = WD_W'(w_ext);
        end
        priority if (h_ext == '0) begin
            h_clamped = ROW_W'(1);
        end else if (h_ext > CHW'(MAX_HEIGHT)) begin
            h_clamped = ROW_W'(MAX_HEIGHT);
        end else begin
            h_clamped = ROW_W'(h_ext);
        end
    end

    assign eff_w = frame_start_reg ? w_clamped : act_w_reg;
    assign eff_h = frame_start_reg ? h_clamped : act_h_reg;

    assign pix_phase    = in_row_reg < eff_h;
    assign col_end      = WD_W'(in_col_reg) == (eff_w - WD_W'(1));
    assign out_col_last = WD_W'(out_col_reg) == (eff_w - WD_W'(1));
    assign out_row_last = out_row_reg == (eff_h - ROW_W'(1));

    // drain while pixels are still due is dropped
    assign take = item_accept && !(drain && pix_phase);
    assign col  = in_col_reg;

    assign info.wr           = pix_phase;
    assign info.par          = in_row_reg[0];
    assign info.emit         = lead_done_reg;
    assign info.last         = lead_done_reg && out_col_last && out_row_last;
    assign info.edges.top    = out_row_reg != '0;
    assign info.edges.bottom = !out_row_last;
    assign info.edges.left   = out_col_reg != '0;
    assign info.edges.right  = !out_col_last;

    always_comb begin
        act_w_next       = item_accept ? eff_w : act_w_reg;
        act_h_next       = item_accept ? eff_h : act_h_reg;
        in_col_next      = in_col_reg;
        in_row_next      = in_row_reg;
        out_col_next     = out_col_reg;
        out_row_next     = out_row_reg;
        lead_cnt_next    = lead_cnt_reg;
        lead_done_next   = lead_done_reg;
        frame_start_next = frame_start_reg;
        if (take) begin
            if (info.last) begin
                in_col_next      = '0;
                in_row_next      = '0;
                out_col_next     = '0;
                out_row_next     = '0;
                lead_cnt_next    = '0;
                lead_done_next   = 1'b0;
                frame_start_next = 1'b1;
            end else begin
                frame_start_next = 1'b0;
                if (col_end) begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
                if (lead_done_reg) begin
                    if (out_col_last) begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + ROW_W'(1);
                    end else begin
                        out_col_next = out_col_reg + COL_W'(1);
                    end
                end else begin
                    lead_cnt_next  = lead_cnt_reg + WD_W'(1);
                    lead_done_next = lead_cnt_reg == eff_w;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_w_reg       <= WD_W'(1);
            act_h_reg       <= ROW_W'(1);
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            out_col_reg     <= '0;
            out_row_reg     <= '0;
            lead_cnt_reg    <= '0;
            lead_done_reg   <= 1'b0;
            frame_start_reg <= 1'b1;
        end else begin
            act_w_reg       <= act_w_next;
            act_h_reg       <= act_h_next;
            in_col_reg      <= in_col_next;
            in_row_reg      <= in_row_next;
            out_col_reg     <= out_col_next;
            out_row_reg     <= out_row_next;
            lead_cnt_reg    <= lead_cnt_next;
            lead_done_reg   <= lead_done_next;
            frame_start_reg <= frame_start_next;
        end
    end

    a_last_restarts_frame: assert property (
        @(posedge aclk) disable iff (!aresetn)
        take && info.last |=> frame_start_reg && in_row_reg == '0 && !lead_done_reg
    ) else $error("counters not cleared after last result of frame");

    a_col_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !frame_start_reg |-> WD_W'(in_col_reg) < act_w_reg
    ) else $error("input column beyond latched width");

endmodule

// File: rtl/bb3_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_linebuf
// Two line memories, rows alternating by parity; read-first, registered read.
// ----------------------------------------------------------------------------
module bb3_linebuf #(
    parameter int  MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic                wr_en,
    input  logic                par,
    input  logic [COL_W-1:0]    addr,
    input  bb3_pkg::rgb_t       wdata,
    output bb3_pkg::rgb_t       older,
    output bb3_pkg::rgb_t       newer
);

    bb3_pkg::rgb_t mem0 [MAX_WIDTH];
    bb3_pkg::rgb_t mem1 [MAX_WIDTH];
    bb3_pkg::rgb_t q0_reg;
    bb3_pkg::rgb_t q1_reg;
    logic          par_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && !par) begin
                mem0[addr] <= wdata;
            end
            q0_reg <= mem0[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && par) begin
                mem1[addr] <= wdata;
            end
            q1_reg <= mem1[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            par_reg <= par;
        end
    end

    // row two above lives in the memory being overwritten
    assign older = par_reg ? q1_reg : q0_reg;
    assign newer = par_reg ? q0_reg : q1_reg;

endmodule

// File: rtl/bb3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window
// 3x3 window shift register and the clipped per-channel neighborhood sums.
// ----------------------------------------------------------------------------
module bb3_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take,
    input  bb3_pkg::scan_t              info,
    input  bb3_pkg::rgb_t               pix,
    input  bb3_pkg::rgb_t               older,
    input  bb3_pkg::rgb_t               newer,
    output logic                        in_ready,
    output logic                        sum_valid,
    input  logic                        sum_ready,
    output bb3_pkg::sum_vec_t           sums,
    output logic [bb3_pkg::CNT_W-1:0]   cnt,
    output logic                        sum_last
);

    logic           s1_valid_reg;
    bb3_pkg::scan_t s1_info_reg;
    bb3_pkg::rgb_t  s1_pix_reg;

    bb3_pkg::rgb_t  win_reg [3][3];
    logic           s2_valid_reg;
    bb3_pkg::edge_t s2_edge_reg;
    logic           s2_last_reg;

    logic                      s3_valid_reg;
    bb3_pkg::sum_vec_t         s3_sum_reg;
    logic [bb3_pkg::CNT_W-1:0] s3_cnt_reg;
    logic                      s3_last_reg;

    logic s1_move, s2_move, s3_move;
    logic s1_rdy, s2_rdy, s3_rdy;

    logic [8:0]        use_mask;
    bb3_pkg::sum_vec_t col_sum [3];
    bb3_pkg::sum_vec_t sum_comb;

    assign s3_rdy  = !s3_valid_reg || sum_ready;
    assign s2_rdy  = !s2_valid_reg || s3_rdy;
    assign s1_rdy  = !s1_valid_reg || s2_rdy;
    assign s3_move = s3_valid_reg && sum_ready;
    assign s2_move = s2_valid_reg && s3_rdy;
    assign s1_move = s1_valid_reg && s2_rdy;

    assign in_ready = s1_rdy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move) begin
                s2_valid_reg <= s1_info_reg.emit;
            end else if (s2_move) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_move) begin
                s3_valid_reg <= 1'b1;
            end else if (s3_move) begin
                s3_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_info_reg <= info;
            s1_pix_reg  <= pix;
        end
        if (s1_move) begin
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= older;
            win_reg[2][1] <= newer;
            win_reg[2][2] <= s1_pix_reg;
            s2_edge_reg   <= s1_info_reg.edges;
            s2_last_reg   <= s1_info_reg.last;
        end
        if (s2_move) begin
            s3_sum_reg  <= sum_comb;
            s3_cnt_reg  <= bb3_pkg::CNT_W'($countones(use_mask));
            s3_last_reg <= s2_last_reg;
        end
    end

    always_comb begin
        bb3_pkg::chan_vec_t px;
        for (int c = 0; c < 3; c++) begin
            col_sum[c] = '0;
            for (int r = 0; r < 3; r++) begin
                use_mask[c*3+r] = (r != 0 || s2_edge_reg.top)
                               && (r != 2 || s2_edge_reg.bottom)
                               && (c != 0 || s2_edge_reg.left)
                               && (c != 2 || s2_edge_reg.right);
                px = win_reg[c][r];
                for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
                    if (use_mask[c*3+r]) begin
                        col_sum[c][ch] = col_sum[c][ch] + bb3_pkg::SUM_W'(px[ch]);
                    end
                end
            end
        end
        for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
            sum_comb[ch] = col_sum[0][ch] + col_sum[1][ch] + col_sum[2][ch];
        end
    end

    assign sum_valid = s3_valid_reg;
    assign sums      = s3_sum_reg;
    assign cnt       = s3_cnt_reg;
    assign sum_last  = s3_last_reg;

    a_count_legal: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_cnt_reg == 4'd1 || s3_cnt_reg == 4'd2 || s3_cnt_reg == 4'd3
                       || s3_cnt_reg == 4'd4 || s3_cnt_reg == 4'd6 || s3_cnt_reg == 4'd9)
    ) else $error("neighborhood size is not a clipped 3x3 window");

endmodule

// File: rtl/bb3_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_mean
// Rounded mean (2*sum+count)/(2*count) by reciprocal multiply; output beat
// register.
// ----------------------------------------------------------------------------
module bb3_mean (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  bb3_pkg::sum_vec_t           sums,
    input  logic [bb3_pkg::CNT_W-1:0]   cnt,
    input  logic                        in_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bb3_pkg::rgb_t               m_data,
    output logic                        m_last
);

    localparam int NUM_W       = bb3_pkg::SUM_W + 1;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // ceil(2^16 / (2*n)); exact for every numerator up to 2*2295+9
    function automatic logic [RECIP_W-1:0] recip(input logic [bb3_pkg::CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        unique case (n)
            4'd1:    m = 16'd32768;
            4'd2:    m = 16'd16384;
            4'd3:    m = 16'd10923;
            4'd4:    m = 16'd8192;
            4'd5:    m = 16'd6554;
            4'd6:    m = 16'd5462;
            4'd7:    m = 16'd4682;
            4'd8:    m = 16'd4096;
            4'd9:    m = 16'd3641;
            default: m = '0;
        endcase
        return m;
    endfunction

    logic                m_valid_reg;
    bb3_pkg::chan_vec_t  q_reg;
    logic                last_reg;
    bb3_pkg::chan_vec_t  q_comb;
    logic [RECIP_W-1:0]  rcp;

    assign in_ready = !m_valid_reg || m_ready;
    assign rcp      = recip(cnt);

    always_comb begin
        logic [NUM_W-1:0]  num;
        logic [PROD_W-1:0] prod;
        for (int ch = 0; ch < bb3_pkg::NUM_CH; ch++) begin
            num        = {sums[ch], 1'b0} + NUM_W'(cnt);
            prod       = PROD_W'(num) * PROD_W'(rcp);
            q_comb[ch] = prod[RECIP_SHIFT +: bb3_pkg::CH_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            q_reg    <= q_comb;
            last_reg <= in_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = q_reg;
    assign m_last  = last_reg;

endmodule

// File: rtl/box_blur_3x3_edge_aware_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core
// Streaming 3x3 box blur of RGB pixels with the window clipped to the frame.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock in raster order and returns, per pixel, the
// per-channel rounded mean of its 3x3 neighborhood inside the frame (1, 2, 3,
// 4, 6 or 9 pixels). The sustained rate is one beat per clock in and out
// while m_axis_tready stays high: each beat does one read-first access to the
// same column of two single-port line memories, and the window, sum and
// divide stages are registered. A result is formed frame_width+1 beats after
// its pixel; after the last pixel of a frame send frame_width+1 beats with
// tuser set to flush, the last result carries tlast. The frame size is taken
// from the registers on the first beat of each frame; widths and heights of
// zero act as one and values above MAX_WIDTH or MAX_HEIGHT are clipped. A
// stalled output backs beats up into the sum, window and input registers.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_core #(
    parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [bb3_pkg::TDATA_W-1:0]    s_axis_tdata,  // in_red, in_green, in_blue
    input  logic                           s_axis_tuser,  // drain
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bb3_pkg::TDATA_W-1:0]    m_axis_tdata,  // out_red, out_green, out_blue
    output logic                           m_axis_tlast   // frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                      item_accept;
    logic                      take;
    bb3_pkg::scan_t            info;
    logic [COL_W-1:0]          col;
    bb3_pkg::rgb_t             pix;
    bb3_pkg::rgb_t             older;
    bb3_pkg::rgb_t             newer;
    logic                      sum_valid;
    logic                      sum_ready;
    bb3_pkg::sum_vec_t         sums;
    logic [bb3_pkg::CNT_W-1:0] cnt;
    logic                      sum_last;
    bb3_pkg::rgb_t             out_pix;

    assign item_accept = s_axis_tvalid && s_axis_tready;
    assign pix         = s_axis_tdata;

    bb3_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .drain       (s_axis_tuser),
        .take        (take),
        .info        (info),
        .col         (col)
    );

    bb3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .aclk  (aclk),
        .rd_en (take),
        .wr_en (info.wr),
        .par   (info.par),
        .addr  (col),
        .wdata (pix),
        .older (older),
        .newer (newer)
    );

    bb3_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (take),
        .info      (info),
        .pix       (pix),
        .older     (older),
        .newer     (newer),
        .in_ready  (s_axis_tready),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sums      (sums),
        .cnt       (cnt),
        .sum_last  (sum_last)
    );

    bb3_mean u_mean (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (sum_valid),
        .in_ready (sum_ready),
        .sums     (sums),
        .cnt      (cnt),
        .in_last  (sum_last),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (out_pix),
        .m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = out_pix;

    a_stall_only_when_full: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready
    ) else $error("input stalled while output side can move");

endmodule
